@@ src/assert_macros.svh @@
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpdb check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LPDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpdb check failed");

`endif

@@ src/lpdb_pkg.sv @@
// Shared types, constants and helpers for the dead-zone blanker.
// No dependencies.
package lpdb_pkg;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int ATT_W   = 13;
    localparam int BOUND_W = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam logic [ATT_W-1:0] ATT_FULL = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE0       = 3'd3;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic snap_step;
        logic blend_mul;
        logic blend_sum;
        logic div_step;
        logic eval2;
        logic dim;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic ison_now;
        logic ison_held;
        logic last_vis;
        logic hit;
        logic snap_last;
    } status_t;

    function automatic logic [ATT_W-1:0] clamp_att(input logic [ATT_W-1:0] a);
        return (a > ATT_FULL) ? ATT_FULL : a;
    endfunction

    // c * (4096 - a) + 2048, then drop 12 fraction bits
    function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c,
                                                     input logic [ATT_W-1:0] a);
        logic [ATT_W-1:0] k;
        logic [COLOR_W+ATT_W:0] p;
        k = ATT_FULL - a;
        p = (COLOR_W+ATT_W+1)'(c) * (COLOR_W+ATT_W+1)'(k) + (COLOR_W+ATT_W+1)'(2048);
        return p[COLOR_W+11:12];
    endfunction

endpackage

@@ src/lpdb_ctrl.sv @@
// Sequencer for the dead-zone blanker: issues datapath commands per state.
// Depends on lpdb_pkg.
module lpdb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lpdb_pkg::status_t status,
    output lpdb_pkg::cmd_t    cmd
);
    import lpdb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_SNAP  = 9'b000000100,
        S_BLMUL = 9'b000001000,
        S_BLSUM = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_EVAL2 = 9'b001000000,
        S_DIM   = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (!status.enabled || (status.last_vis && status.ison_now))
                    state_next = S_FIN;
                else if (!status.last_vis && !status.ison_now)
                    state_next = S_DIM;
                else
                    state_next = S_SNAP;
            end
            S_SNAP:
            begin
                cmd.snap_step = 1'b1;
                if (status.hit || status.snap_last)
                    state_next = S_BLMUL;
            end
            S_BLMUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_BLSUM;
            end
            S_BLSUM:
            begin
                cmd.blend_sum = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = status.ison_held ? S_FIN : S_EVAL2;
            end
            S_EVAL2:
            begin
                cmd.eval2  = 1'b1;
                state_next = S_DIM;
            end
            S_DIM:
            begin
                cmd.dim    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/lpdb_datapath.sv @@
// Datapath of the dead-zone blanker: config store, zone test, snap search,
// blend, constant divider and color dimming. Depends on lpdb_pkg.
module lpdb_datapath #(
    parameter int ZONE_COUNT = 4,
    parameter int SNAP_STEPS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lpdb_pkg::cmd_t                       cmd,
    output lpdb_pkg::status_t                    status,
    input  logic signed [lpdb_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [lpdb_pkg::COORD_W-1:0]  pos_y,
    input  logic [lpdb_pkg::COLOR_W-1:0]         red_in,
    input  logic [lpdb_pkg::COLOR_W-1:0]         green_in,
    input  logic [lpdb_pkg::COLOR_W-1:0]         blue_in,
    input  logic                                 cfg_wr_en,
    input  logic [lpdb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpdb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [lpdb_pkg::COORD_W-1:0]  out_x,
    output logic signed [lpdb_pkg::COORD_W-1:0]  out_y,
    output logic [lpdb_pkg::COLOR_W-1:0]         red_out,
    output logic [lpdb_pkg::COLOR_W-1:0]         green_out,
    output logic [lpdb_pkg::COLOR_W-1:0]         blue_out
);
    import lpdb_pkg::*;

    localparam int S2    = 2 * SNAP_STEPS;
    localparam int SW    = $clog2(S2);
    localparam int FW    = SW + 1;
    localparam int NPW   = COORD_W + SW + 2;
    localparam int CW    = NPW + 10;
    localparam int NW    = NPW + 17;
    localparam int DW    = COORD_W + SW;
    localparam int KSH   = DW + SW;
    localparam int MW    = DW + 2;
    localparam int CNT_W = (SNAP_STEPS > 1) ? $clog2(SNAP_STEPS) : 1;
    localparam logic signed [CW-1:0] SCALE    = CW'(S2);
    localparam logic signed [NW-1:0] HALF_DEN = NW'(2048 * S2);
    localparam logic signed [NW-1:0] Q_OFFSET = NW'(S2 * 32768);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SNAP_STEPS - 1);
    // ceil(2^KSH / S2): exact floor division for any dividend below 2^DW
    localparam logic [MW-1:0]    RECIP    = MW'(((longint'(1) << KSH) + S2 - 1) / S2);

    // configuration
    logic                       enabled_reg, reverse_reg;
    logic [ATT_W-1:0]           def_att_reg;
    logic                       live_reg [ZONE_COUNT];
    logic signed [BOUND_W-1:0]  xlo_reg [ZONE_COUNT];
    logic signed [BOUND_W-1:0]  xhi_reg [ZONE_COUNT];
    logic signed [BOUND_W-1:0]  ylo_reg [ZONE_COUNT];
    logic signed [BOUND_W-1:0]  yhi_reg [ZONE_COUNT];
    logic [ATT_W-1:0]           zatt_reg [ZONE_COUNT];

    // bounds of the zone word being written, in Q23
    logic signed [11:0]        cfg_cx, cfg_cy;
    logic [11:0]               cfg_w, cfg_h;
    logic [ATT_W-1:0]          cfg_wc, cfg_hc;
    logic signed [BOUND_W-1:0] cfg_mx, cfg_my, cfg_hw, cfg_hh;

    assign cfg_cx = $signed(cfg_data[11:0]);
    assign cfg_cy = $signed(cfg_data[23:12]);
    assign cfg_w  = cfg_data[35:24];
    assign cfg_h  = cfg_data[47:36];
    assign cfg_wc = ATT_FULL - {1'b0, cfg_w};
    assign cfg_hc = ATT_FULL - {1'b0, cfg_h};
    assign cfg_mx = cfg_cx * $signed({1'b0, cfg_wc});
    assign cfg_my = cfg_cy * $signed({1'b0, cfg_hc});
    assign cfg_hw = $signed({3'b000, cfg_w, 11'b0});
    assign cfg_hh = $signed({3'b000, cfg_h, 11'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            reverse_reg <= 1'b0;
            def_att_reg <= ATT_FULL;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_ENABLED)
                enabled_reg <= cfg_data[0];
            if (cfg_index == REG_REVERSE)
                reverse_reg <= cfg_data[0];
            if (cfg_index == REG_DEFAULT_ATT)
                def_att_reg <= clamp_att(cfg_data[ATT_W-1:0]);
        end
    end

    for (genvar k = 0; k < ZONE_COUNT; k++)
    begin : g_zone
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                live_reg[k] <= 1'b0;
                xlo_reg[k]  <= '0;
                xhi_reg[k]  <= '0;
                ylo_reg[k]  <= '0;
                yhi_reg[k]  <= '0;
                zatt_reg[k] <= '0;
            end
            else if (cfg_wr_en && (cfg_index == REG_ZONE0 + CFG_IDX_W'(k)))
            begin
                live_reg[k] <= (cfg_w != '0) && (cfg_h != '0);
                xlo_reg[k]  <= cfg_mx - cfg_hw;
                xhi_reg[k]  <= cfg_mx + cfg_hw;
                ylo_reg[k]  <= cfg_my - cfg_hh;
                yhi_reg[k]  <= cfg_my + cfg_hh;
                zatt_reg[k] <= clamp_att(cfg_data[60:48]);
            end
        end
    end

    // item state
    logic signed [COORD_W-1:0] x_reg, y_reg, last_x_reg, last_y_reg;
    logic [COLOR_W-1:0]        r_reg, g_reg, b_reg;
    logic                      last_vis_reg, ison_reg;
    logic [ATT_W-1:0]          z_reg, a_reg;
    logic signed [NPW-1:0]     nx_reg, ny_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [NW-1:0]      p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [DW-1:0]             mx_reg, my_reg;

    // snap candidate
    logic [FW-1:0]         f, g;
    logic signed [NPW-1:0] tx, ty;
    assign f  = FW'({cnt_reg, 1'b1});
    assign g  = FW'(S2) - f;
    assign tx = NPW'(last_x_reg * $signed({1'b0, g})) + NPW'(x_reg * $signed({1'b0, f}));
    assign ty = NPW'(last_y_reg * $signed({1'b0, g})) + NPW'(y_reg * $signed({1'b0, f}));

    // zone test on the current point or the snap candidate
    logic signed [NPW-1:0] qx, qy;
    logic signed [CW-1:0]  ppx, ppy;
    logic                  scaled;
    logic [ZONE_COUNT-1:0] cov;
    logic                  outside;
    logic [ATT_W-1:0]      best, att_now;

    assign scaled = cmd.snap_step;
    assign qx  = scaled ? tx : NPW'(x_reg);
    assign qy  = scaled ? ty : NPW'(y_reg);
    assign ppx = CW'(qx) <<< 9;
    assign ppy = CW'(qy) <<< 9;

    always_comb
    begin
        logic signed [CW-1:0] lx, hx, ly, hy;
        best = '0;
        for (int k = 0; k < ZONE_COUNT; k++)
        begin
            lx = scaled ? CW'(xlo_reg[k]) * SCALE : CW'(xlo_reg[k]);
            hx = scaled ? CW'(xhi_reg[k]) * SCALE : CW'(xhi_reg[k]);
            ly = scaled ? CW'(ylo_reg[k]) * SCALE : CW'(ylo_reg[k]);
            hy = scaled ? CW'(yhi_reg[k]) * SCALE : CW'(yhi_reg[k]);
            cov[k] = live_reg[k] && (ppx >= lx) && (ppx <= hx) && (ppy >= ly) && (ppy <= hy);
            if (cov[k] && (zatt_reg[k] > best))
                best = zatt_reg[k];
        end
    end

    assign outside = ~|cov;
    assign att_now = (best != '0) ? best : def_att_reg;

    // blend sum and quotient offset
    logic signed [NW-1:0] sumx, sumy, mpx, mpy;
    assign sumx = p1x_reg + p2x_reg * NW'(S2) + HALF_DEN;
    assign sumy = p1y_reg + p2y_reg * NW'(S2) + HALF_DEN;
    assign mpx  = (sumx >>> 12) + Q_OFFSET;
    assign mpy  = (sumy >>> 12) + Q_OFFSET;

    // divide the offset sum by 2*SNAP_STEPS through the reciprocal
    logic [DW+MW-1:0]   prodx, prody;
    logic [COORD_W-1:0] qnx, qny;
    assign prodx = (DW+MW)'(mx_reg) * (DW+MW)'(RECIP);
    assign prody = (DW+MW)'(my_reg) * (DW+MW)'(RECIP);
    assign qnx   = prodx[KSH +: COORD_W];
    assign qny   = prody[KSH +: COORD_W];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            r_reg <= red_in;
            g_reg <= green_in;
            b_reg <= blue_in;
        end
        if (cmd.eval)
        begin
            ison_reg <= outside ^ reverse_reg;
            z_reg    <= att_now;
            a_reg    <= att_now;
            nx_reg   <= NPW'(last_x_reg * $signed({1'b0, FW'(S2)}));
            ny_reg   <= NPW'(last_y_reg * $signed({1'b0, FW'(S2)}));
            cnt_reg  <= '0;
        end
        if (cmd.snap_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (outside == last_vis_reg)
            begin
                nx_reg <= tx;
                ny_reg <= ty;
            end
        end
        if (cmd.blend_mul)
        begin
            p1x_reg <= NW'(nx_reg * $signed({1'b0, z_reg}));
            p1y_reg <= NW'(ny_reg * $signed({1'b0, z_reg}));
            p2x_reg <= NW'(x_reg * $signed({1'b0, ATT_FULL - z_reg}));
            p2y_reg <= NW'(y_reg * $signed({1'b0, ATT_FULL - z_reg}));
        end
        if (cmd.blend_sum)
        begin
            mx_reg <= mpx[DW-1:0];
            my_reg <= mpy[DW-1:0];
        end
        if (cmd.div_step)
        begin
            // remove the offset: flip the sign bit of the quotient
            x_reg <= $signed({~qnx[COORD_W-1], qnx[COORD_W-2:0]});
            y_reg <= $signed({~qny[COORD_W-1], qny[COORD_W-2:0]});
        end
        if (cmd.eval2)
            a_reg <= att_now;
        if (cmd.dim)
        begin
            r_reg <= dim_color(r_reg, a_reg);
            g_reg <= dim_color(g_reg, a_reg);
            b_reg <= dim_color(b_reg, a_reg);
        end
        if (cmd.finish)
        begin
            out_x     <= x_reg;
            out_y     <= y_reg;
            red_out   <= r_reg;
            green_out <= g_reg;
            blue_out  <= b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_vis_reg <= 1'b0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
        end
        else if (cmd.finish && enabled_reg)
        begin
            last_vis_reg <= ison_reg;
            last_x_reg   <= x_reg;
            last_y_reg   <= y_reg;
        end
    end

    assign status.enabled   = enabled_reg;
    assign status.ison_now  = outside ^ reverse_reg;
    assign status.ison_held = ison_reg;
    assign status.last_vis  = last_vis_reg;
    assign status.hit       = (outside == last_vis_reg);
    assign status.snap_last = (cnt_reg == CNT_LAST);

endmodule

@@ src/laser_point_deadzone_blanker_core.sv @@
// Laser point dead-zone blanker. One point is taken at a time: a beat is
// accepted only while the sequencer is idle, which is from the cycle in which
// the previous result lands in the output register (later while that
// register still holds an unaccepted beat). A point that stays visible, or
// any point while the block is disabled, goes from the zone test straight
// to the result; a point that stays hidden is dimmed first. A point that
// changes visibility runs the snap search, one interpolation step per cycle
// for at most SNAP_STEPS steps, then a blend multiply and a blend sum, a
// reciprocal multiply for the divide by 2*SNAP_STEPS, and, when hidden, a
// new zone test at the snapped point and the dimming.
module laser_point_deadzone_blanker_core #(
    parameter int ZONE_COUNT = 4,
    parameter int SNAP_STEPS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lpdb_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [lpdb_pkg::COORD_W-1:0]  pos_y,
    input  logic [lpdb_pkg::COLOR_W-1:0]         red_in,
    input  logic [lpdb_pkg::COLOR_W-1:0]         green_in,
    input  logic [lpdb_pkg::COLOR_W-1:0]         blue_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lpdb_pkg::COORD_W-1:0]  out_x,
    output logic signed [lpdb_pkg::COORD_W-1:0]  out_y,
    output logic [lpdb_pkg::COLOR_W-1:0]         red_out,
    output logic [lpdb_pkg::COLOR_W-1:0]         green_out,
    output logic [lpdb_pkg::COLOR_W-1:0]         blue_out,
    input  logic                                 cfg_wr_en,
    input  logic [lpdb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpdb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lpdb_pkg::*;

    cmd_t    cmd;
    status_t status;

    lpdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lpdb_datapath #(
        .ZONE_COUNT (ZONE_COUNT),
        .SNAP_STEPS (SNAP_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_x     (out_x),
        .out_y     (out_y),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

@@ src/lpdb_checker.sv @@
// Port-level checks on the dead-zone blanker, bound to the top level.
// Depends on assert_macros.svh and lpdb_pkg.
`include "assert_macros.svh"

module lpdb_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [lpdb_pkg::COORD_W-1:0] out_x,
    input logic signed [lpdb_pkg::COORD_W-1:0] out_y
);

    // a stalled result beat holds its position
    `LPDB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y))

    // one point at a time: no second beat right after an accept
    `LPDB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // handshake outputs are always driven out of reset
    `LPDB_ASSERT_NOW(a_hs_known, 1'b1, !$isunknown({in_ready, out_valid}))

endmodule

bind laser_point_deadzone_blanker_core lpdb_checker u_lpdb_checker (.*);
